@@ rtl/core/msr_pkg.sv @@
// Package for the motor speed ramp core: word types, action codes,
// register indexes and widths. No dependencies.
package msr_pkg;

   localparam int SPEED_W   = 8;
   localparam int DUTY_W    = 7;
   localparam int ACCEL_W   = 7;
   localparam int IVAL_W    = 16;
   localparam int ELAPSED_W = 17;
   localparam int THR_W     = 26;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;
   localparam logic [ACCEL_W-1:0]        ACCEL_MAX = 7'd100;
   localparam logic [ELAPSED_W-1:0]      ELAPSED_TOP = '1;

   localparam logic [ACCEL_W-1:0] ACCEL_RESET = 7'd100;
   localparam logic [IVAL_W-1:0]  MIN_RESET   = 16'd1000;
   localparam logic [IVAL_W-1:0]  MAX_RESET   = 16'd10000;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_SET  = 2'd1,
      ACT_STOP = 2'd2
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX    = 2'd3;

   typedef struct packed {
      logic [1:0]                action;
      logic signed [SPEED_W-1:0] target_speed;
   } req_word_type;

   typedef struct packed {
      logic [DUTY_W-1:0]         forward_duty;
      logic [DUTY_W-1:0]         backward_duty;
      logic signed [SPEED_W-1:0] present_speed;
      logic                      ramping;
   } rsp_word_type;

   // settings handed from the register block to the ramp stage
   typedef struct packed {
      logic                      enable;
      logic [IVAL_W-1:0]         min_interval;
      logic signed [THR_W-1:0]   step_thr;
   } cfg_type;

endpackage

@@ rtl/core/msr_csr.sv @@
// Configuration registers and the step threshold derived from them.
// Depends on msr_pkg.
module msr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [msr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msr_pkg::CSR_DATA_W-1:0]   csr_data,
   output msr_pkg::cfg_type                 cfg
);

   logic                                enable_ff;
   logic [msr_pkg::ACCEL_W-1:0]         accel_ff;
   logic [msr_pkg::IVAL_W-1:0]          min_ff;
   logic [msr_pkg::IVAL_W-1:0]          max_ff;
   logic signed [msr_pkg::THR_W-1:0]    thr_ff;
   logic signed [msr_pkg::THR_W-1:0]    thr_in;

   logic [msr_pkg::ACCEL_W-1:0]         accel_sat;
   logic signed [msr_pkg::IVAL_W:0]     span;
   logic signed [24:0]                  prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         accel_ff  <= msr_pkg::ACCEL_RESET;
         min_ff    <= msr_pkg::MIN_RESET;
         max_ff    <= msr_pkg::MAX_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            msr_pkg::CSR_ENABLE: enable_ff <= csr_data[0];
            msr_pkg::CSR_ACCEL:  accel_ff  <= csr_data[msr_pkg::ACCEL_W-1:0];
            msr_pkg::CSR_MIN:    min_ff    <= csr_data;
            msr_pkg::CSR_MAX:    max_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // interval = min + trunc(a*(max-min)/100); a tick steps when
   // 100*(elapsed-min) > p for p >= 0, or > p+99 for p < 0
   always_comb begin
      accel_sat = (accel_ff > msr_pkg::ACCEL_MAX) ? msr_pkg::ACCEL_MAX : accel_ff;
      span      = $signed({1'b0, max_ff}) - $signed({1'b0, min_ff});
      prod      = $signed({1'b0, accel_sat}) * span;
      if (prod[24]) begin
         thr_in = $signed({prod[24], prod}) + 26'sd99;
      end else begin
         thr_in = $signed({prod[24], prod});
      end
   end

   always_ff @(posedge clock) begin
      thr_ff <= thr_in;
   end

   assign cfg.enable       = enable_ff;
   assign cfg.min_interval = min_ff;
   assign cfg.step_thr     = thr_ff;

endmodule

@@ rtl/core/msr_ramp.sv @@
// Ramp stage: speed state update per word and the result register.
// Depends on msr_pkg.
module msr_ramp (
   input  logic                   clock,
   input  logic                   reset,
   input  msr_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   input  msr_pkg::req_word_type  in_word,
   output logic                   in_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output msr_pkg::rsp_word_type  rsp_word
);

   logic signed [msr_pkg::SPEED_W-1:0]  speed_ff, speed_in;
   logic signed [msr_pkg::SPEED_W-1:0]  goal_ff, goal_in;
   logic [msr_pkg::ELAPSED_W-1:0]       elapsed_ff, elapsed_in;
   logic                                flag_ff, flag_in;
   logic                                valid_ff, valid_in;
   msr_pkg::rsp_word_type               word_ff, word_in;

   logic                                take;
   logic [msr_pkg::ELAPSED_W-1:0]       elapsed_inc;
   logic signed [msr_pkg::ELAPSED_W:0]  rel;
   logic signed [msr_pkg::THR_W-1:0]    rel_ext;
   logic signed [msr_pkg::THR_W-1:0]    rel_x100;
   logic signed [msr_pkg::SPEED_W-1:0]  tgt_sat;
   logic signed [msr_pkg::SPEED_W-1:0]  speed_neg;

   assign in_ready = !valid_ff || !rsp_stall;
   assign take     = in_valid && in_ready;

   always_comb begin
      speed_in   = speed_ff;
      goal_in    = goal_ff;
      elapsed_in = elapsed_ff;
      flag_in    = flag_ff;

      elapsed_inc = (elapsed_ff == msr_pkg::ELAPSED_TOP) ? elapsed_ff
                                                         : elapsed_ff + 1'b1;
      rel      = $signed({1'b0, elapsed_inc}) - $signed({2'b00, cfg.min_interval});
      rel_ext  = {{(msr_pkg::THR_W-msr_pkg::ELAPSED_W-1){rel[msr_pkg::ELAPSED_W]}}, rel};
      rel_x100 = (rel_ext <<< 6) + (rel_ext <<< 5) + (rel_ext <<< 2);

      if (in_word.target_speed > msr_pkg::SPEED_MAX) begin
         tgt_sat = msr_pkg::SPEED_MAX;
      end else if (in_word.target_speed < msr_pkg::SPEED_MIN) begin
         tgt_sat = msr_pkg::SPEED_MIN;
      end else begin
         tgt_sat = in_word.target_speed;
      end

      if (take && cfg.enable) begin
         unique case (in_word.action)
            msr_pkg::ACT_TICK: begin
               elapsed_in = elapsed_inc;
               if (rel_x100 > cfg.step_thr) begin
                  elapsed_in = '0;
                  if (goal_ff > speed_ff) begin
                     speed_in = speed_ff + 8'sd1;
                     flag_in  = 1'b1;
                  end else if (goal_ff < speed_ff) begin
                     speed_in = speed_ff - 8'sd1;
                     flag_in  = 1'b1;
                  end else begin
                     flag_in  = 1'b0;
                  end
               end
            end
            msr_pkg::ACT_SET:  goal_in = tgt_sat;
            msr_pkg::ACT_STOP: begin
               speed_in = '0;
               goal_in  = '0;
            end
            default: ;
         endcase
      end

      speed_neg = -speed_in;
      word_in   = '0;
      if (cfg.enable) begin
         word_in.forward_duty  = (speed_in > 8'sd0) ? speed_in[msr_pkg::DUTY_W-1:0] : '0;
         word_in.backward_duty = (speed_in < 8'sd0) ? speed_neg[msr_pkg::DUTY_W-1:0] : '0;
         word_in.present_speed = speed_in;
         word_in.ramping       = flag_in;
      end

      valid_in = take || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= '0;
         goal_ff    <= '0;
         elapsed_ff <= '0;
         flag_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         speed_ff   <= speed_in;
         goal_ff    <= goal_in;
         elapsed_ff <= elapsed_in;
         flag_ff    <= flag_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      speed_ff <= msr_pkg::SPEED_MAX && speed_ff >= msr_pkg::SPEED_MIN)
      else $error("speed out of range");

   a_goal_range: assert property (@(posedge clock) disable iff (reset)
      goal_ff <= msr_pkg::SPEED_MAX && goal_ff >= msr_pkg::SPEED_MIN)
      else $error("goal out of range");

   a_speed_slew: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(speed_ff))
      else $error("speed moved without a word");

   a_duty_split: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (word_ff.forward_duty == '0 || word_ff.backward_duty == '0))
      else $error("both duties nonzero");

   a_disabled_idle: assert property (@(posedge clock) disable iff (reset)
      !cfg.enable |=> $stable(speed_ff) && $stable(goal_ff) && $stable(elapsed_ff))
      else $error("state changed while disabled");

endmodule

@@ rtl/core/motor_speed_ramp_hbridge_core.sv @@
// Top level of the motor speed ramp for an H-bridge driver.
// Depends on msr_pkg, msr_csr and msr_ramp.
//
// Usage:
//   req channel: one word per action (tick of one microsecond, set target,
//   stop), taken when req_valid is high and req_stall low.
//   rsp channel: exactly one word per request word, in order, with the
//   forward/backward duty split, the present speed and the ramping flag.
//   csr port: write-only; csr_write with csr_index 0..3 (enable, accel
//   setting, min interval, max interval). Write only while the core is
//   empty, at least two cycles before the next request word.
// Path: a taken word passes the input register, then the ramp logic into
//   the result register, from which it is presented on rsp.
// Throughput: one word per cycle while rsp_stall is low.
// Reset: all control state clears; speed, target and elapsed count go to
//   zero, registers return to enable 0, accel 100, min 1000, max 10000.
// Stall: rsp_stall holds the result word; the input register keeps one
//   more word, after which req_stall rises.
module motor_speed_ramp_hbridge_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  msr_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output msr_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_write,
   input  logic [msr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msr_pkg::CSR_DATA_W-1:0]   csr_data
);

   msr_pkg::cfg_type       cfg;
   logic                   in_valid_ff, in_valid_in;
   msr_pkg::req_word_type  in_word_ff;
   logic                   ramp_ready;
   logic                   accept;

   assign req_stall   = in_valid_ff && !ramp_ready;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !ramp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
   end

   msr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   msr_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_word   (in_word_ff),
      .in_ready  (ramp_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for motor_speed_ramp_hbridge_core: a queue-fed driver,
// a monitor and a predictor of the speed ramp and its duty split.
// Depends on msr_pkg and the core RTL.
module testbench;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int PCT = 100;
   localparam int ELAPSED_LIM = 2 ** msr_pkg::ELAPSED_W - 1;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   msr_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   msr_pkg::rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [msr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [msr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   msr_pkg::req_word_type pending_words[$];
   msr_pkg::rsp_word_type duty_expected[$];
   msr_pkg::rsp_word_type want;

   // ramp state and settings as the core should hold them
   bit cfg_enable = 1'b0;
   int cfg_accel = int'(msr_pkg::ACCEL_RESET);
   int cfg_min = int'(msr_pkg::MIN_RESET);
   int cfg_max = int'(msr_pkg::MAX_RESET);
   int ramp_speed = 0;
   int ramp_goal = 0;
   int ramp_elapsed = 0;
   bit ramp_flag = 1'b0;

   int failures = 0;
   int n_sent = 0;
   int n_rsp = 0;
   int tx_wait = 0;
   int rx_wait = 0;
   int cycles = 0;

   motor_speed_ramp_hbridge_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic msr_pkg::rsp_word_type ramp_predict(msr_pkg::req_word_type w);
      msr_pkg::rsp_word_type r;
      int a;
      int ival;
      int t;
      int mag;
      r = '0;
      if (!cfg_enable) return r;
      case (w.action)
         msr_pkg::ACT_TICK: begin
            if (ramp_elapsed < ELAPSED_LIM) ramp_elapsed++;
            a = (cfg_accel > PCT) ? PCT : cfg_accel;
            ival = cfg_min + (a * (cfg_max - cfg_min)) / PCT;
            if (ramp_elapsed > ival) begin
               ramp_elapsed = 0;
               if (ramp_goal > ramp_speed) begin
                  ramp_speed++;
                  ramp_flag = 1'b1;
               end else if (ramp_goal < ramp_speed) begin
                  ramp_speed--;
                  ramp_flag = 1'b1;
               end else begin
                  ramp_flag = 1'b0;
               end
            end
         end
         msr_pkg::ACT_SET: begin
            t = int'(w.target_speed);
            if (t > PCT) t = PCT;
            if (t < -PCT) t = -PCT;
            ramp_goal = t;
         end
         msr_pkg::ACT_STOP: begin
            ramp_speed = 0;
            ramp_goal = 0;
         end
         default: ;
      endcase
      mag = -ramp_speed;
      r.forward_duty = (ramp_speed > 0) ? ramp_speed[msr_pkg::DUTY_W-1:0] : '0;
      r.backward_duty = (ramp_speed < 0) ? mag[msr_pkg::DUTY_W-1:0] : '0;
      r.present_speed = ramp_speed[msr_pkg::SPEED_W-1:0];
      r.ramping = ramp_flag;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            duty_expected.push_back(ramp_predict(req_word));
            n_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
               tx_wait = (((n_sent >> 6) % 5) == 4) ? 0 : int'($urandom_range(0, 5));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int e, int g);
      if (e != g) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, e, g);
         failures++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (duty_expected.size() == 0) begin
               $display("%0t: no word expected, got %h", $time, rsp_word);
               failures++;
            end else begin
               want = duty_expected.pop_front();
               check_field("forward_duty", int'(want.forward_duty),
                           int'(rsp_word.forward_duty));
               check_field("backward_duty", int'(want.backward_duty),
                           int'(rsp_word.backward_duty));
               check_field("present_speed", int'(want.present_speed),
                           int'(rsp_word.present_speed));
               check_field("ramping", int'(want.ramping), int'(rsp_word.ramping));
            end
            n_rsp++;
            if (n_rsp == 100 || n_rsp == 620) rx_wait = 60;
            else if (((n_rsp >> 6) % 5) == 2) rx_wait = 0;
            else rx_wait = int'($urandom_range(0, 5));
         end
         rsp_stall <= (rx_wait > 0);
         if (rx_wait > 0) rx_wait--;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[motor_speed_ramp_hbridge_core] ERROR");
         $finish;
      end
   end

   task automatic push_word(logic [1:0] act, logic [7:0] t);
      msr_pkg::req_word_type w;
      w.action = act;
      w.target_speed = t;
      pending_words.push_back(w);
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || duty_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(logic [msr_pkg::CSR_DATA_W-1:0] en,
                             logic [msr_pkg::CSR_DATA_W-1:0] accel,
                             logic [msr_pkg::CSR_DATA_W-1:0] mn,
                             logic [msr_pkg::CSR_DATA_W-1:0] mx);
      csr_write <= 1'b1;
      csr_index <= msr_pkg::CSR_ENABLE;
      csr_data <= en;
      cfg_enable = en[0];
      @(posedge clock);
      csr_index <= msr_pkg::CSR_ACCEL;
      csr_data <= accel;
      cfg_accel = int'(accel[msr_pkg::ACCEL_W-1:0]);
      @(posedge clock);
      csr_index <= msr_pkg::CSR_MIN;
      csr_data <= mn;
      cfg_min = int'(mn);
      @(posedge clock);
      csr_index <= msr_pkg::CSR_MAX;
      csr_data <= mx;
      cfg_max = int'(mx);
      @(posedge clock);
      csr_write <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // segments of one target followed by a run of ticks, with stops and unused codes mixed in
   task automatic fill_random(int count);
      int n;
      int k;
      int sel;
      logic [7:0] t;
      n = 0;
      while (n < count) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            push_word(msr_pkg::ACT_STOP, 8'($urandom));
         end else if (sel == 1) begin
            push_word(ACT_NONE, 8'($urandom));
         end else begin
            sel = $urandom_range(0, 19);
            if (sel < 12) t = 8'(int'($urandom_range(0, 20)) - 10);
            else if (sel < 17) t = 8'(int'($urandom_range(0, 200)) - 100);
            else t = 8'($urandom);
            push_word(msr_pkg::ACT_SET, t);
         end
         n++;
         k = ($urandom_range(0, 9) == 0) ? 150 : int'($urandom_range(2, 40));
         repeat (k) begin
            if (n < count) begin
               push_word(msr_pkg::ACT_TICK, 8'($urandom));
               n++;
            end
         end
      end
   endtask

   task automatic run_phase(logic [msr_pkg::CSR_DATA_W-1:0] en,
                            logic [msr_pkg::CSR_DATA_W-1:0] accel,
                            logic [msr_pkg::CSR_DATA_W-1:0] mn,
                            logic [msr_pkg::CSR_DATA_W-1:0] mx,
                            int count);
      wait_drained();
      write_regs(en, accel, mn, mx);
      fill_random(count);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: every word reads zero
      push_word(msr_pkg::ACT_TICK, 8'h00);
      push_word(msr_pkg::ACT_SET, 8'd100);
      push_word(msr_pkg::ACT_STOP, 8'h00);
      push_word(ACT_NONE, 8'hFF);
      wait_drained();

      // interval of 2: a step every third tick
      write_regs(16'd1, 16'd0, 16'd2, 16'd9);
      push_word(msr_pkg::ACT_SET, 8'h7F);
      repeat (6) push_word(msr_pkg::ACT_TICK, 8'h00);
      push_word(msr_pkg::ACT_SET, 8'h80);
      repeat (3) push_word(msr_pkg::ACT_TICK, 8'hFF);
      push_word(msr_pkg::ACT_SET, 8'h00);
      repeat (6) push_word(msr_pkg::ACT_TICK, 8'h00);
      push_word(msr_pkg::ACT_STOP, 8'h7F);
      push_word(ACT_NONE, 8'h80);
      push_word(msr_pkg::ACT_SET, 8'h9C);
      repeat (3) push_word(msr_pkg::ACT_TICK, 8'h00);
      push_word(msr_pkg::ACT_STOP, 8'h00);

      run_phase(16'd1, 16'd0, 16'd0, 16'd0, 160);
      run_phase(16'd1, 16'd100, 16'd3, 16'd1, 160);
      run_phase(16'd1, 16'd127, 16'd0, 16'd4, 160);
      run_phase(16'd1, 16'd50, 16'd7, 16'd2, 160);
      run_phase(16'd1, 16'd33, 16'd1, 16'd6, 160);
      run_phase(16'd0, 16'd10, 16'd2, 16'd5, 160);
      run_phase(16'd1, 16'd100, 16'd65535, 16'd65535, 40);
      run_phase(16'd1, 16'd0, 16'd65535, 16'd0, 40);

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0 && duty_expected.size() == 0) begin
         $display("[motor_speed_ramp_hbridge_core] OK");
      end else begin
         $display("[motor_speed_ramp_hbridge_core] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/msr_pkg.sv
rtl/core/msr_csr.sv
rtl/core/msr_ramp.sv
rtl/core/motor_speed_ramp_hbridge_core.sv
test/testbench.sv
